/* sv/dtes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_pkg: shared types and constants for the date/time to epoch converter
// Status codes, stage payload types and the calendar tables.
// ----------------------------------------------------------------------------
package dtes_pkg;

  // Field widths
  localparam int unsigned YearW   = 7;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 6;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned ZoneW   = 5;
  localparam int unsigned EpochW  = 33;
  localparam int unsigned StatusW = 3;

  // Internal widths
  localparam int unsigned DaysW    = 17;  // signed day count, -1 .. ~36530
  localparam int unsigned HourSumW = 7;   // signed hour plus offset
  localparam int unsigned HourSecW = 19;  // signed seconds from the hour term
  localparam int unsigned MinSecW  = 12;  // minute*60 + second

  // Calendar constants
  localparam int unsigned BaseYear   = 70;
  localparam int unsigned LeapBase   = 69;
  localparam int unsigned Century    = 100;
  localparam int unsigned DaysInYear = 365;
  localparam int unsigned SecPerDay  = 86400;
  localparam int unsigned SecPerHour = 3600;
  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned MaxHour    = 23;
  localparam int unsigned MaxMinute  = 59;
  localparam int unsigned MaxSecond  = 59;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK     = 3'd0,
    STATUS_MONTH  = 3'd1,
    STATUS_DAY    = 3'd2,
    STATUS_HOUR   = 3'd3,
    STATUS_MINUTE = 3'd4,
    STATUS_SECOND = 3'd5
  } status_e;

  // Stage one result: checked fields and day count
  typedef struct packed {
    status_e                  status;
    logic signed [DaysW-1:0]  days;
    logic [HourW-1:0]         hour;
    logic [MinW-1:0]          minute;
    logic [SecW-1:0]          second;
  } dec_t;

  // Stage two result: scaled partial terms
  typedef struct packed {
    status_e                    status;
    logic signed [EpochW-1:0]   day_sec;
    logic signed [HourSecW-1:0] hour_sec;
    logic [MinSecW-1:0]         min_sec;
  } scl_t;

  // Days before the first of each month in a common year
  function automatic logic [8:0] month_start(input logic [MonthW-1:0] mo);
    logic [8:0] r;
    case (mo)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Last accepted day of a month
  function automatic logic [DayW-1:0] month_limit(input logic [MonthW-1:0] mo,
                                                  input logic leap);
    logic [DayW-1:0] r;
    case (mo)
      4'd4, 4'd6, 4'd9, 4'd11: r = 6'd30;
      4'd2:                    r = leap ? 6'd29 : 6'd28;
      default:                 r = 6'd31;
    endcase
    return r;
  endfunction

endpackage

/* sv/dtes_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_if: channel interfaces of the date/time to epoch converter
// Input request, result and configuration write channels.
// ----------------------------------------------------------------------------

// Input request: one calendar date and time
interface dtes_in_if;
  logic                           valid;
  logic                           ready;
  logic [dtes_pkg::YearW-1:0]     year_two_digit;
  logic [dtes_pkg::MonthW-1:0]    month;
  logic [dtes_pkg::DayW-1:0]      day;
  logic [dtes_pkg::HourW-1:0]     hour;
  logic [dtes_pkg::MinW-1:0]      minute;
  logic [dtes_pkg::SecW-1:0]      second;

  modport source (output valid, year_two_digit, month, day, hour, minute, second,
                  input ready);
  modport sink   (input valid, year_two_digit, month, day, hour, minute, second,
                  output ready);
endinterface

// Result: epoch seconds and status
interface dtes_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dtes_pkg::EpochW-1:0]  epoch_seconds;
  logic [dtes_pkg::StatusW-1:0]        status;

  modport source (output valid, epoch_seconds, status, input ready);
  modport sink   (input valid, epoch_seconds, status, output ready);
endinterface

// Configuration write: zone offset in hours
interface dtes_cfg_if;
  logic                               valid;
  logic                               ready;
  logic signed [dtes_pkg::ZoneW-1:0]  zone_offset_hours;

  modport source (output valid, zone_offset_hours, input ready);
  modport sink   (input valid, zone_offset_hours, output ready);
endinterface

/* sv/dtes_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_decode: field checks and day count (pipeline stage one)
// Range checks in order, leap test, and days since 1970 for the date.
// ----------------------------------------------------------------------------
module dtes_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [dtes_pkg::YearW-1:0]    year_i,
  input  logic [dtes_pkg::MonthW-1:0]   month_i,
  input  logic [dtes_pkg::DayW-1:0]     day_i,
  input  logic [dtes_pkg::HourW-1:0]    hour_i,
  input  logic [dtes_pkg::MinW-1:0]     minute_i,
  input  logic [dtes_pkg::SecW-1:0]     second_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output dtes_pkg::dec_t                data_o
);

  logic                  leap;
  logic [7:0]            full_year;
  logic [6:0]            year_off;
  logic [4:0]            leap_days;
  logic [15:0]           year_days;
  logic [15:0]           date_days;
  dtes_pkg::status_e     status;
  logic                  valid_q;
  dtes_pkg::dec_t        data_d, data_q;

  // Year 00 counts as common
  assign leap = (year_i != '0) && (year_i[1:0] == 2'b00);

  // Two-digit years below 70 are 20xx
  assign full_year = (year_i < 7'(dtes_pkg::BaseYear))
                   ? 8'(year_i) + 8'(dtes_pkg::Century) : 8'(year_i);
  assign year_off  = 7'(full_year - 8'(dtes_pkg::BaseYear));
  assign leap_days = 5'((full_year - 8'(dtes_pkg::LeapBase)) >> 2);
  assign year_days = 16'(year_off) * 16'(dtes_pkg::DaysInYear);

  assign date_days = year_days + 16'(leap_days) + 16'(dtes_pkg::month_start(month_i))
                   + 16'((month_i > 4'd2) && leap);

  // Checks in order, first failure wins
  always_comb begin
    if (month_i < 4'd1 || month_i > 4'd12) begin
      status = dtes_pkg::STATUS_MONTH;
    end else if (day_i > dtes_pkg::month_limit(month_i, leap)) begin
      status = dtes_pkg::STATUS_DAY;
    end else if (hour_i > 5'(dtes_pkg::MaxHour)) begin
      status = dtes_pkg::STATUS_HOUR;
    end else if (minute_i > 6'(dtes_pkg::MaxMinute)) begin
      status = dtes_pkg::STATUS_MINUTE;
    end else if (second_i > 6'(dtes_pkg::MaxSecond)) begin
      status = dtes_pkg::STATUS_SECOND;
    end else begin
      status = dtes_pkg::STATUS_OK;
    end
  end

  // Day zero is the day before day one
  always_comb begin
    data_d.status = status;
    data_d.days   = $signed({1'b0, date_days}) + $signed({11'b0, day_i})
                  - 17'sd1;
    data_d.hour   = hour_i;
    data_d.minute = minute_i;
    data_d.second = second_i;
  end

  // Stage register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/dtes_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_scale: conversion of day, hour and minute to seconds (stage two)
// Constant multiplies of day count, offset hour and minute; adds the second.
// ----------------------------------------------------------------------------
module dtes_scale (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [dtes_pkg::ZoneW-1:0]  zone_i,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  dtes_pkg::dec_t                     data_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output dtes_pkg::scl_t                     data_o
);

  logic signed [dtes_pkg::HourSumW-1:0] hour_sum;
  logic                                 valid_q;
  dtes_pkg::scl_t                       data_d, data_q;

  // Hour with zone offset, signed
  assign hour_sum = $signed({2'b00, data_i.hour}) + dtes_pkg::HourSumW'(zone_i);

  always_comb begin
    data_d.status   = data_i.status;
    data_d.day_sec  = dtes_pkg::EpochW'(data_i.days)
                    * $signed(dtes_pkg::EpochW'(dtes_pkg::SecPerDay));
    data_d.hour_sec = dtes_pkg::HourSecW'(hour_sum)
                    * $signed(dtes_pkg::HourSecW'(dtes_pkg::SecPerHour));
    data_d.min_sec  = 12'(data_i.minute) * 12'(dtes_pkg::SecPerMin)
                    + 12'(data_i.second);
  end

  // Stage register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/dtes_sum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_sum: final sum and result register (stage three)
// Adds the partial terms; a failed check gives zero.
// ----------------------------------------------------------------------------
module dtes_sum (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  dtes_pkg::scl_t                       data_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [dtes_pkg::EpochW-1:0]   epoch_o,
  output logic [dtes_pkg::StatusW-1:0]         status_o
);

  logic signed [dtes_pkg::EpochW-1:0] total;
  logic                               valid_q;
  logic signed [dtes_pkg::EpochW-1:0] epoch_d, epoch_q;
  logic [dtes_pkg::StatusW-1:0]       status_q;

  assign total = data_i.day_sec + dtes_pkg::EpochW'(data_i.hour_sec)
               + $signed(dtes_pkg::EpochW'(data_i.min_sec));

  assign epoch_d = (data_i.status == dtes_pkg::STATUS_OK) ? total : '0;

  // Output register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      epoch_q  <= epoch_d;
      status_q <= data_i.status;
    end
  end

  assign valid_o  = valid_q;
  assign epoch_o  = epoch_q;
  assign status_o = status_q;

endmodule

/* sv/date_time_to_epoch_seconds.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_time_to_epoch_seconds: calendar date and time to seconds since 1970
// Three-stage pipeline: checks and day count, scaling, sum.
// ----------------------------------------------------------------------------
//  Channel   Dir   Carries
//  in_i      sink  year_two_digit, month, day, hour, minute, second
//  out_o     src   epoch_seconds, status
//  cfg_i     sink  zone_offset_hours (always ready)
//
// One request per cycle while out_o is ready; each stage output is registered.
// Each stage holds its own valid bit and advances when the next is empty or
// moving, so a stalled result does not stop the stages behind it filling.
// Reset clears the valid bits and sets the zone offset to minus one.
// The zone offset is sampled in stage two.
// ----------------------------------------------------------------------------
module date_time_to_epoch_seconds (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtes_in_if.sink    in_i,
  dtes_out_if.source out_o,
  dtes_cfg_if.sink   cfg_i
);

  logic signed [dtes_pkg::ZoneW-1:0] zone_q;
  logic                              dec_valid, dec_ready;
  logic                              scl_valid, scl_ready;
  dtes_pkg::dec_t                    dec_data;
  dtes_pkg::scl_t                    scl_data;

  // Zone offset register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= -5'sd1;
    end else if (cfg_i.valid) begin
      zone_q <= cfg_i.zone_offset_hours;
    end
  end

  dtes_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .year_i   (in_i.year_two_digit),
    .month_i  (in_i.month),
    .day_i    (in_i.day),
    .hour_i   (in_i.hour),
    .minute_i (in_i.minute),
    .second_i (in_i.second),
    .valid_o  (dec_valid),
    .ready_i  (dec_ready),
    .data_o   (dec_data)
  );

  dtes_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .zone_i  (zone_q),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .data_i  (dec_data),
    .valid_o (scl_valid),
    .ready_i (scl_ready),
    .data_o  (scl_data)
  );

  dtes_sum u_sum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (scl_valid),
    .ready_o  (scl_ready),
    .data_i   (scl_data),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .epoch_o  (out_o.epoch_seconds),
    .status_o (out_o.status)
  );

endmodule
